### rtl/sfr_pkg.sv
// Shared types and constants for the servo frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_BODY  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_ID    = 2'd0,
    ROLE_LEN   = 2'd1,
    ROLE_PARAM = 2'd2,
    ROLE_CHK   = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD       = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_ABORTED   = 2'd3
  } status_e;

  typedef struct packed {
    logic       kind;     // 1 = idle timeout event
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    role_e      byte_role;
    logic       frame_end;
    status_e    frame_status;
  } res_t;

endpackage

### rtl/sfr_in_stage.sv
// Input register of the servo frame receiver.
// Depends on sfr_pkg (item_t).
module sfr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfr_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output sfr_pkg::item_t item_o
);
  import sfr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Register is free when empty or when its transaction moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/sfr_parser.sv
// Frame parser: header hunt, role tagging, running checksum.
// Depends on sfr_pkg (phase_e, role_e, status_e, item_t, res_t).
module sfr_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  sfr_pkg::item_t item_i,
  output logic          res_valid_o,
  output sfr_pkg::res_t  res_o
);
  import sfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;   // body bytes still due, checksum included
  logic [7:0] sum_q, sum_d;
  logic       timeout;
  logic [7:0] b;

  assign timeout = item_i.kind;
  assign b       = item_i.rx_byte;

  // Next state
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    sum_d   = sum_q;
    if (advance_i) begin
      case (phase_q)
        PH_HUNT2: begin
          if (!timeout && b == HDR_BYTE) begin
            phase_d = PH_ID;
          end else begin
            phase_d = PH_HUNT1;
            left_d  = '0;
            sum_d   = '0;
          end
        end
        PH_ID, PH_LEN: begin
          if (timeout) begin
            phase_d = PH_HUNT1;
            left_d  = '0;
            sum_d   = '0;
          end else if (phase_q == PH_ID) begin
            sum_d   = b;
            phase_d = PH_LEN;
          end else begin
            sum_d   = sum_q + b;
            left_d  = (b == 8'd0) ? 8'd1 : b;  // length zero acts as one
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (!timeout && left_q > 8'd1) begin
            sum_d  = sum_q + b;
            left_d = left_q - 8'd1;
          end else begin
            phase_d = PH_HUNT1;
            left_d  = '0;
            sum_d   = '0;
          end
        end
        default: begin
          phase_d = (!timeout && b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
          left_d  = '0;
          sum_d   = '0;
        end
      endcase
    end
  end

  // Result of the current transaction
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.has_byte     = 1'b0;
    res_o.out_byte     = '0;
    res_o.byte_role    = ROLE_ID;
    res_o.frame_end    = 1'b0;
    res_o.frame_status = ST_GOOD;
    case (phase_q)
      PH_ID, PH_LEN: begin
        res_valid_o = 1'b1;
        if (timeout) begin
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_ABORTED;
        end else begin
          res_o.has_byte  = 1'b1;
          res_o.out_byte  = b;
          res_o.byte_role = (phase_q == PH_ID) ? ROLE_ID : ROLE_LEN;
        end
      end
      PH_BODY: begin
        res_valid_o = 1'b1;
        if (timeout) begin
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_TRUNCATED;
        end else if (left_q > 8'd1) begin
          res_o.has_byte  = 1'b1;
          res_o.out_byte  = b;
          res_o.byte_role = ROLE_PARAM;
        end else begin
          res_o.has_byte     = 1'b1;
          res_o.out_byte     = b;
          res_o.byte_role    = ROLE_CHK;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = (~sum_q == b) ? ST_GOOD : ST_BAD;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      left_q  <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
    end
  end

endmodule

### rtl/sfr_out_stage.sv
// Result register of the servo frame receiver.
// Depends on sfr_pkg (res_t).
module sfr_out_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  logic         res_valid_i,
  input  sfr_pkg::res_t res_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output sfr_pkg::res_t res_o
);
  import sfr_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (advance_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/servo_frame_receiver.sv
// Servo frame receiver, top level: input register, parser, result register.
// Depends on sfr_pkg, sfr_in_stage, sfr_parser, sfr_out_stage.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one event per transaction:
//   kind_i = 0 with a received byte in rx_byte_i, or kind_i = 1 for a link
//   idle timeout. The block hunts for FF FF, then emits the ID, length,
//   parameter and checksum bytes tagged by byte_role_o on the output channel
//   (out_valid_o/out_ready_o). frame_end_o marks the last result of a frame,
//   with frame_status_o giving good/bad checksum, truncated or aborted.
//   Header bytes and ignored timeouts produce no output transaction.
//   Path: a result passes from the input register through the parser into the
//   result register and then shows on out_valid_o; while the result register
//   is not free, its input transaction waits in the input register.
//   Throughput: one input transaction per cycle while the output is not
//   stalled; parser state is updated once per event.
//   Reset: the parser returns to header hunting with sum and count cleared;
//   both registers empty.
//   Stall: while the result register holds an untaken result, the input
//   register can still take one more transaction; after that in_ready_o drops.
module servo_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] byte_role_o,
  output logic       frame_end_o,
  output logic [1:0] frame_status_o
);
  import sfr_pkg::*;

  item_t in_item, s1_item;
  res_t  p_res, o_res;
  logic  s1_valid, p_res_valid, out_free, advance;

  assign in_item.kind    = kind_i;
  assign in_item.rx_byte = rx_byte_i;
  assign advance         = s1_valid && out_free;

  sfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  sfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_item),
    .res_valid_o (p_res_valid),
    .res_o       (p_res)
  );

  sfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .res_valid_i (p_res_valid),
    .res_i       (p_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (o_res)
  );

  assign has_byte_o     = o_res.has_byte;
  assign out_byte_o     = o_res.out_byte;
  assign byte_role_o    = o_res.byte_role;
  assign frame_end_o    = o_res.frame_end;
  assign frame_status_o = o_res.frame_status;

endmodule

### rtl/sfr_checker.sv
// Port-level checks for the servo frame receiver, bound to the top level.
// Depends on sfr_pkg and servo_frame_receiver.
module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       has_byte_o,
  input logic [7:0] out_byte_o,
  input logic [1:0] byte_role_o,
  input logic       frame_end_o,
  input logic [1:0] frame_status_o
);
  import sfr_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("result dropped or changed while stalled");

  // Status only means something at the end of a frame.
  a_status_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> has_byte_o && frame_status_o == ST_GOOD)
    else $error("status or empty result in mid frame");

  // A byte-less result is always a timeout end.
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |->
      frame_end_o && (frame_status_o == ST_TRUNCATED || frame_status_o == ST_ABORTED))
    else $error("empty result without timeout status");

  // The checksum byte and only it closes a frame that carries a byte.
  a_chk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |->
      ((byte_role_o == ROLE_CHK) == frame_end_o) &&
      (frame_status_o == ST_GOOD || frame_status_o == ST_BAD))
    else $error("checksum role and frame end disagree");

endmodule

bind servo_frame_receiver sfr_checker u_sfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .has_byte_o     (has_byte_o),
  .out_byte_o     (out_byte_o),
  .byte_role_o    (byte_role_o),
  .frame_end_o    (frame_end_o),
  .frame_status_o (frame_status_o)
);

### tb/sv/tb_servo_frame_receiver.sv
// Self-checking testbench for servo_frame_receiver: directed and random byte/timeout traffic.
// A frame tracker class predicts each result and checks it on the output side.
// Depends on sfr_pkg and the servo_frame_receiver RTL.
module tb_servo_frame_receiver;
  import sfr_pkg::*;

  localparam logic EV_BYTE    = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  localparam int RANDOM_EVENTS = 1000;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_AT       = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 2000;

  // Tracks parser state from accepted events and holds the results still due.
  class frame_tracker;
    phase_e     phase;
    logic [8:0] bytes_left;
    logic [7:0] sum;
    res_t       due_results[$];
    int         errors;
    int         n_results;
    int         n_status[4];

    function new();
      restart();
      errors    = 0;
      n_results = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void restart();
      phase      = PH_HUNT1;
      bytes_left = '0;
      sum        = '0;
    endfunction

    function void take_event(logic kind, logic [7:0] b);
      res_t r;
      bit   emit;
      r    = '0;
      emit = 1'b0;
      case (phase)
        PH_HUNT2: begin
          if (!kind && b == HDR_BYTE) phase = PH_ID;
          else restart();
        end
        PH_ID, PH_LEN: begin
          emit = 1'b1;
          if (kind) begin
            restart();
            r.frame_end    = 1'b1;
            r.frame_status = ST_ABORTED;
          end else if (phase == PH_ID) begin
            sum         = b;
            phase       = PH_LEN;
            r.has_byte  = 1'b1;
            r.out_byte  = b;
            r.byte_role = ROLE_ID;
          end else begin
            sum         = sum + b;
            bytes_left  = (b == 8'd0) ? 9'd1 : {1'b0, b};
            phase       = PH_BODY;
            r.has_byte  = 1'b1;
            r.out_byte  = b;
            r.byte_role = ROLE_LEN;
          end
        end
        PH_BODY: begin
          emit = 1'b1;
          if (kind) begin
            restart();
            r.frame_end    = 1'b1;
            r.frame_status = ST_TRUNCATED;
          end else if (bytes_left > 9'd1) begin
            sum         = sum + b;
            bytes_left  = bytes_left - 9'd1;
            r.has_byte  = 1'b1;
            r.out_byte  = b;
            r.byte_role = ROLE_PARAM;
          end else begin
            r.has_byte     = 1'b1;
            r.out_byte     = b;
            r.byte_role    = ROLE_CHK;
            r.frame_end    = 1'b1;
            r.frame_status = (b == ~sum) ? ST_GOOD : ST_BAD;
            restart();
          end
        end
        default: begin
          restart();
          if (!kind && b == HDR_BYTE) phase = PH_HUNT2;
        end
      endcase
      if (emit) due_results = {due_results, r};
    endfunction

    function void match_result(logic has, logic [7:0] ob, logic [1:0] role, logic fe,
                               logic [1:0] fs);
      res_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: has_byte=%0d out_byte=%02h role=%0d end=%0d status=%0d",
               has, ob, role, fe, fs);
        errors++;
        return;
      end
      want = due_results.pop_front();
      n_results++;
      if (want.frame_end) n_status[want.frame_status]++;
      if (has !== want.has_byte) begin
        $error("has_byte: expected %0d, got %0d", want.has_byte, has);
        errors++;
      end
      if (ob !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, ob);
        errors++;
      end
      if (role !== want.byte_role) begin
        $error("byte_role: expected %0d, got %0d", want.byte_role, role);
        errors++;
      end
      if (fe !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, fe);
        errors++;
      end
      if (fs !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, fs);
        errors++;
      end
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid_r  = 1'b0;
  logic       kind_r      = 1'b0;
  logic [7:0] rx_byte_r   = 8'd0;
  logic       out_ready_r = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       has_byte_o;
  logic [7:0] out_byte_o;
  logic [1:0] byte_role_o;
  logic       frame_end_o;
  logic [1:0] frame_status_o;

  frame_tracker tracker = new();
  int n_events   = 0;
  int n_timeouts = 0;
  int burst_left = 1;

  servo_frame_receiver dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid_r),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_r),
    .rx_byte_i     (rx_byte_r),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_r),
    .has_byte_o    (has_byte_o),
    .out_byte_o    (out_byte_o),
    .byte_role_o   (byte_role_o),
    .frame_end_o   (frame_end_o),
    .frame_status_o(frame_status_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender runs in bursts; valid drops only when a gap follows.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_r <= 1'b0;
        kind_r     <= 1'($urandom);
        rx_byte_r  <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_event(input logic kind, input logic [7:0] b);
    kind_r     <= kind;
    rx_byte_r  <= b;
    in_valid_r <= 1'b1;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    tracker.take_event(kind, b);
    n_events++;
    if (kind) n_timeouts++;
    pace_sender();
  endtask

  // cut: body position replaced by a timeout (0 = ID, 1 = length, 2.. = params/checksum).
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit good,
                            input int cut);
    logic [7:0] sum;
    logic [7:0] val;
    int         nbody;
    int         pos;
    nbody = (len == 8'd0) ? 1 : int'(len);
    sum   = id + len;
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    for (pos = 0; pos < nbody + 2; pos++) begin
      if (pos == cut) begin
        send_event(EV_TIMEOUT, 8'($urandom));
        return;
      end
      if (pos == 0) val = id;
      else if (pos == 1) val = len;
      else if (pos < nbody + 1) begin
        val = 8'($urandom);
        sum = sum + val;
      end else val = good ? ~sum : (~sum ^ 8'($urandom_range(1, 255)));
      send_event(EV_BYTE, val);
    end
  endtask

  initial begin : result_sink
    int cyc;
    int mode;
    bit held;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid_o && out_ready_r)
        tracker.match_result(has_byte_o, out_byte_o, byte_role_o, frame_end_o,
                             frame_status_o);
      cyc++;
      if (cyc % 80 == 0) mode = $urandom_range(0, 3);
      if (!held && n_events >= HOLD_AT) begin
        // long back-pressure so the input side fills and stalls
        held = 1'b1;
        out_ready_r <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          0: out_ready_r <= 1'b1;
          1: out_ready_r <= 1'($urandom_range(0, 1));
          2: out_ready_r <= (cyc % 7) >= 2;
          default: out_ready_r <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid_r && in_ready_o) || (out_valid_o && out_ready_r)) idle = 0;
      else idle++;
    end
    $display("servo_frame_receiver: mismatch");
    $finish;
  end

  initial begin : stimulus
    int         n0;
    int         pick;
    bit         big_done;
    logic [7:0] id;
    logic [7:0] len;
    big_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // timeout while hunting is ignored
    send_event(EV_TIMEOUT, 8'hFF);
    // broken header by a plain byte, then by a timeout
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, 8'h00);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_TIMEOUT, 8'h00);
    // abort while the ID is awaited
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_TIMEOUT, 8'hA5);
    // third FF taken as ID, then abort before the length byte
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_TIMEOUT, 8'h5A);
    // zero length: next byte is the checksum, good here
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, 8'h00);
    send_event(EV_BYTE, 8'h00);
    send_event(EV_BYTE, 8'hFF);
    // bad checksum, frame still delivered
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, 8'hFE);
    send_event(EV_BYTE, 8'h02);
    send_event(EV_BYTE, 8'h80);
    send_event(EV_BYTE, 8'h00);
    // timeout in the body
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, HDR_BYTE);
    send_event(EV_BYTE, 8'h01);
    send_event(EV_BYTE, 8'h03);
    send_event(EV_BYTE, 8'h55);
    send_event(EV_TIMEOUT, 8'h00);

    n0 = n_events;
    while (n_events - n0 < RANDOM_EVENTS) begin
      pick = $urandom_range(0, 99);
      len  = 8'($urandom_range(0, 8));
      if (!big_done && n_events - n0 > 200) begin
        len      = 8'd255;
        big_done = 1'b1;
      end else if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(9, 255));
      id = ($urandom_range(0, 7) == 0) ? HDR_BYTE : 8'($urandom);
      if (pick < 82 && $urandom_range(0, 3) == 0) send_event(EV_TIMEOUT, 8'($urandom));
      if (pick < 70) send_frame(id, len, $urandom_range(0, 4) != 0, -1);
      else if (pick < 82)
        send_frame(id, len, 1'b1, $urandom_range(0, ((len == 8'd0) ? 1 : int'(len)) + 1));
      else if (pick < 92) begin
        repeat ($urandom_range(1, 6))
          send_event($urandom_range(0, 3) == 0,
                     ($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom));
      end else begin
        send_event(EV_BYTE, HDR_BYTE);
        if ($urandom_range(0, 1)) send_event(EV_TIMEOUT, 8'($urandom));
        else send_event(EV_BYTE, 8'($urandom_range(0, 254)));
      end
    end
    in_valid_r <= 1'b0;

    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d events (%0d timeouts); checked %0d results.",
             n_events, n_timeouts, tracker.n_results);
    $display("Frames closed: %0d good, %0d bad checksum, %0d truncated, %0d aborted.",
             tracker.n_status[ST_GOOD], tracker.n_status[ST_BAD],
             tracker.n_status[ST_TRUNCATED], tracker.n_status[ST_ABORTED]);
    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("servo_frame_receiver: match");
    end else begin
      $display("servo_frame_receiver: mismatch");
    end
    $finish;
  end
endmodule
